FILE: hdl/mlpsig_pkg.sv
`default_nettype none
package mlpsig_pkg;

   localparam int MAX_WIDTH    = 16;
   localparam int MAX_HIDDEN   = 4;
   localparam int WEIGHT_DEPTH = 2048;
   localparam int WADDR_W      = $clog2(WEIGHT_DEPTH);
   localparam int ACT_IDX_W    = $clog2(MAX_WIDTH);
   localparam int CFG_W        = 5;
   localparam int LAYER_W      = 3;
   localparam int SIG_W        = 9;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_INPUT_COUNT  = 2'd0;
   localparam logic [1:0] CSR_OUTPUT_COUNT = 2'd1;
   localparam logic [1:0] CSR_HIDDEN       = 2'd2;
   localparam logic [1:0] CSR_NEURONS      = 2'd3;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic                 wr_weight;
      logic [WADDR_W-1:0]   waddr;
      logic                 wr_input;
      logic [ACT_IDX_W-1:0] in_idx;
      logic                 issue;
      logic                 first;
      logic                 thr;
      logic [WADDR_W-1:0]   raddr;
      logic [ACT_IDX_W-1:0] k_idx;
      logic [ACT_IDX_W-1:0] n_idx;
      logic                 bank;
      logic                 emit;
      logic                 emit_err;
      logic                 emit_last;
   } cmd_type;

   // status back from the datapath
   typedef struct packed {
      logic busy;
      logic can_load;
   } status_type;

   // clamp a configuration value into 1..hi
   function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] hi);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) r = CFG_W'(1);
      else if (v > hi) r = hi;
      return r;
   endfunction

   // bitwise restoring quotient, elaboration use only
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // one sigmoid entry, x = (2i+1-256)/32
   function automatic logic [SIG_W-1:0] sig_entry(input int i);
      logic [63:0] c;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] num;
      logic [63:0] q;
      int d;
      int m;
      c = 64'd4162825044;
      e = 64'h1_0000_0000;
      d = 2 * i + 1 - 256;
      m = (d < 0) ? -d : d;
      for (int j = 0; j < m; j++) begin
         e = (e * c + 64'h8000_0000) >> 32;
      end
      den = 64'h1_0000_0000 + e;
      num = (i >= 128) ? 64'h100_0000_0000 : (e << 8);
      q = udiv64(num + (den >> 1), den);
      return q[SIG_W-1:0];
   endfunction

   typedef logic [SIG_W-1:0] sig_tab_type [256];

   function automatic sig_tab_type build_sig;
      sig_tab_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = sig_entry(i);
      end
      return t;
   endfunction

   localparam sig_tab_type SIG_TABLE = build_sig();

endpackage
`default_nettype wire

FILE: hdl/mlpsig_if.sv
`default_nettype none
// request channel: one word per weight or network input
interface mlpsig_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [15:0] value;
   logic               last;
   modport source (output valid, output func, output value, output last, input ready);
   modport sink (input valid, input func, input value, input last, output ready);
endinterface

// response channel: one word per output neuron or error
interface mlpsig_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] out_value;
   logic       out_last;
   logic       count_error;
   modport source (output valid, output out_value, output out_last, output count_error,
                   input ready);
   modport sink (input valid, input out_value, input out_last, input count_error,
                 output ready);
endinterface
`default_nettype wire

FILE: hdl/mlpsig_ram.sv
`default_nettype none
module mlpsig_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

FILE: hdl/mlpsig_ctrl.sv
`default_nettype none
module mlpsig_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [mlpsig_pkg::CFG_W-1:0]  csr_wdata,
   input  wire logic                          req_valid,
   input  wire logic                          req_func,
   input  wire logic                          req_last,
   output logic                               req_ready,
   output mlpsig_pkg::cmd_type                cmd,
   input  wire mlpsig_pkg::status_type        status
);
   import mlpsig_pkg::*;

   typedef enum logic [2:0] {IDLE, ISSUE, DRAIN, EMIT, ERR} state_type;

   state_type          state_ff, state_in;
   logic [CFG_W-1:0]   nin_cfg_ff, nout_cfg_ff, npl_cfg_ff;
   logic [2:0]         nhid_cfg_ff;
   logic [WADDR_W-1:0] wptr_ff, wptr_in;
   logic [WADDR_W-1:0] addr_ff, addr_in;
   logic [CFG_W-1:0]   cnt_ff, cnt_in;
   logic [CFG_W-1:0]   k_ff, k_in;
   logic [CFG_W-1:0]   n_ff, n_in;
   logic [LAYER_W-1:0] lyr_ff, lyr_in;
   logic               bank_ff, bank_in;

   logic [CFG_W-1:0]   nin, nout, npl, fanin, ncount, cnt_next;
   logic [LAYER_W-1:0] nhid;

   assign nin  = clamp_cfg(nin_cfg_ff, CFG_W'(MAX_WIDTH));
   assign nout = clamp_cfg(nout_cfg_ff, CFG_W'(MAX_WIDTH));
   assign npl  = clamp_cfg(npl_cfg_ff, CFG_W'(MAX_WIDTH));
   assign nhid = LAYER_W'(clamp_cfg({2'b00, nhid_cfg_ff}, CFG_W'(MAX_HIDDEN)));
   assign fanin  = (lyr_ff == '0) ? nin : npl;
   assign ncount = (lyr_ff == nhid) ? nout : npl;
   assign cnt_next = (cnt_ff == {CFG_W{1'b1}}) ? cnt_ff : cnt_ff + CFG_W'(1);

   // sequence loading, layer evaluation and result delivery
   always_comb begin
      state_in = state_ff;
      wptr_in  = wptr_ff;
      addr_in  = addr_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      lyr_in   = lyr_ff;
      bank_in  = bank_ff;
      req_ready = 1'b0;
      cmd = '0;
      cmd.waddr  = wptr_ff;
      cmd.in_idx = cnt_ff[ACT_IDX_W-1:0];
      cmd.raddr  = addr_ff;
      cmd.k_idx  = k_ff[ACT_IDX_W-1:0];
      cmd.n_idx  = n_ff[ACT_IDX_W-1:0];
      cmd.bank   = bank_ff;
      case (state_ff)
         IDLE: begin
            req_ready = ~reset;
            if (req_valid && !reset) begin
               if (!req_func) begin
                  cmd.wr_weight = 1'b1;
                  wptr_in = req_last ? '0 : wptr_ff + WADDR_W'(1);
               end else begin
                  cmd.wr_input = (cnt_ff < CFG_W'(MAX_WIDTH));
                  cnt_in = cnt_next;
                  if (req_last) begin
                     cnt_in  = '0;
                     addr_in = '0;
                     k_in    = '0;
                     n_in    = '0;
                     lyr_in  = '0;
                     bank_in = 1'b0;
                     state_in = (cnt_next != nin) ? ERR : ISSUE;
                  end
               end
            end
         end
         ISSUE: begin
            cmd.issue = 1'b1;
            cmd.first = (k_ff == '0);
            cmd.thr   = (k_ff == fanin);
            addr_in = addr_ff + WADDR_W'(1);
            if (k_ff == fanin) begin
               k_in = '0;
               if (n_ff == ncount - CFG_W'(1)) begin
                  n_in = '0;
                  state_in = DRAIN;
               end else begin
                  n_in = n_ff + CFG_W'(1);
               end
            end else begin
               k_in = k_ff + CFG_W'(1);
            end
         end
         DRAIN: begin
            if (!status.busy) begin
               bank_in = ~bank_ff;
               if (lyr_ff == nhid) begin
                  state_in = EMIT;
               end else begin
                  lyr_in = lyr_ff + LAYER_W'(1);
                  state_in = ISSUE;
               end
            end
         end
         EMIT: begin
            if (status.can_load) begin
               cmd.emit = 1'b1;
               cmd.emit_last = (n_ff == nout - CFG_W'(1));
               if (n_ff == nout - CFG_W'(1)) begin
                  n_in = '0;
                  state_in = IDLE;
               end else begin
                  n_in = n_ff + CFG_W'(1);
               end
            end
         end
         ERR: begin
            if (status.can_load) begin
               cmd.emit = 1'b1;
               cmd.emit_err = 1'b1;
               cmd.emit_last = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   // hold state, counters and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         wptr_ff     <= '0;
         addr_ff     <= '0;
         cnt_ff      <= '0;
         k_ff        <= '0;
         n_ff        <= '0;
         lyr_ff      <= '0;
         bank_ff     <= 1'b0;
         nin_cfg_ff  <= CFG_W'(1);
         nout_cfg_ff <= CFG_W'(1);
         nhid_cfg_ff <= 3'd1;
         npl_cfg_ff  <= CFG_W'(1);
      end else begin
         state_ff <= state_in;
         wptr_ff  <= wptr_in;
         addr_ff  <= addr_in;
         cnt_ff   <= cnt_in;
         k_ff     <= k_in;
         n_ff     <= n_in;
         lyr_ff   <= lyr_in;
         bank_ff  <= bank_in;
         if (csr_we) begin
            case (csr_index)
               CSR_INPUT_COUNT:  nin_cfg_ff  <= csr_wdata;
               CSR_OUTPUT_COUNT: nout_cfg_ff <= csr_wdata;
               CSR_HIDDEN:       nhid_cfg_ff <= csr_wdata[2:0];
               CSR_NEURONS:      npl_cfg_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

FILE: hdl/mlpsig_datapath.sv
`default_nettype none
module mlpsig_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mlpsig_pkg::cmd_type   cmd,
   output mlpsig_pkg::status_type     status,
   input  wire logic signed [15:0]    req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [8:0]                 rsp_out_value,
   output logic                       rsp_out_last,
   output logic                       rsp_count_error
);
   import mlpsig_pkg::*;

   logic [15:0]          act_ff [2][MAX_WIDTH];
   logic [15:0]          w_rd;
   logic signed [15:0]   a1_ff;
   logic                 s1_v_ff, s1_thr_ff, s1_first_ff;
   logic [ACT_IDX_W-1:0] s1_n_ff;
   logic signed [32:0]   prod_ff;
   logic                 s2_v_ff, s2_thr_ff, s2_first_ff;
   logic [ACT_IDX_W-1:0] s2_n_ff;
   logic signed [31:0]   acc_ff, acc_in;
   logic                 s3_v_ff, s3_thr_ff;
   logic [ACT_IDX_W-1:0] s3_n_ff;
   logic signed [33:0]   sum, t;
   logic [7:0]           idx;
   logic                 rsp_valid_ff;
   logic [SIG_W-1:0]     rsp_value_ff;
   logic                 rsp_last_ff, rsp_err_ff;

   mlpsig_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_weights (
      .clock (clock),
      .we    (cmd.wr_weight),
      .waddr (cmd.waddr),
      .wdata (req_value),
      .raddr (cmd.raddr),
      .rdata (w_rd)
   );

   // saturate base plus product to 32 bits
   always_comb begin
      sum = (s2_first_ff ? 34'sd0 : 34'(acc_ff)) + 34'(prod_ff);
      if (sum > 34'sh0_7FFF_FFFF) acc_in = 32'sh7FFF_FFFF;
      else if (sum < -34'sh0_8000_0000) acc_in = 32'sh8000_0000;
      else acc_in = sum[31:0];
   end

   // table index over -8..+8
   always_comb begin
      t = 34'(acc_ff) + 34'sd524288;
      if (t < 0) idx = 8'd0;
      else if (t[33:12] > 22'd255) idx = 8'd255;
      else idx = t[19:12];
   end

   // advance the multiply-accumulate pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
      a1_ff       <= act_ff[cmd.bank][cmd.k_idx];
      s1_thr_ff   <= cmd.thr;
      s1_first_ff <= cmd.first;
      s1_n_ff     <= cmd.n_idx;
      prod_ff     <= s1_thr_ff ? -(33'(signed'(w_rd)) <<< 8)
                               : 33'(32'(signed'(w_rd)) * 32'(a1_ff));
      s2_thr_ff   <= s1_thr_ff;
      s2_first_ff <= s1_first_ff;
      s2_n_ff     <= s1_n_ff;
      if (s2_v_ff) acc_ff <= acc_in;
      s3_thr_ff   <= s2_thr_ff;
      s3_n_ff     <= s2_n_ff;
      // store network inputs and neuron outputs
      if (cmd.wr_input) act_ff[0][cmd.in_idx] <= req_value;
      if (s3_v_ff && s3_thr_ff)
         act_ff[~cmd.bank][s3_n_ff] <= {7'd0, SIG_TABLE[idx]};
   end

   // hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_value_ff <= cmd.emit_err ? '0 : act_ff[cmd.bank][cmd.n_idx][SIG_W-1:0];
         rsp_last_ff  <= cmd.emit_last;
         rsp_err_ff   <= cmd.emit_err;
      end
   end

   assign status.busy     = s1_v_ff | s2_v_ff | s3_v_ff;
   assign status.can_load = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_out_last    = rsp_last_ff;
   assign rsp_count_error = rsp_err_ff;
endmodule
`default_nettype wire

FILE: hdl/mlp_sigmoid_forward_pass.sv
// channel   dir  fields                              accepted when
// req_chan  in   func, value[15:0], last             valid && ready
// rsp_chan  out  out_value[8:0], out_last, count_error valid && ready
// csr_*     in   csr_index, csr_wdata                csr_we
//
// Weight words and non-final inputs are stored as they are taken.
// The final input runs every neuron through one shared multiplier:
// one weight read per cycle, fanin weights and a threshold per neuron, a drain per layer,
// then each result word in turn through the output register.
// Requests are refused until the last result word is loaded; a stalled result holds.
// Reset (synchronous) clears the weight pointer and input count and sets each configuration register to 1.
`default_nettype none
module mlp_sigmoid_forward_pass (
   input  wire logic                         clock,
   input  wire logic                         reset,
   mlpsig_req_if.sink                        req_chan,
   mlpsig_rsp_if.source                      rsp_chan,
   input  wire logic                         csr_we,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [mlpsig_pkg::CFG_W-1:0] csr_wdata
);
   import mlpsig_pkg::*;

   cmd_type    cmd;
   status_type status;

   mlpsig_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   mlpsig_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_value       (req_chan.value),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_value   (rsp_chan.out_value),
      .rsp_out_last    (rsp_chan.out_last),
      .rsp_count_error (rsp_chan.count_error)
   );

   // no request taken while the pipeline still works
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !req_chan.ready) else $error("request taken during evaluation");

   // an error word is a lone zero word
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.count_error |-> rsp_chan.out_last &&
      rsp_chan.out_value == 9'd0) else $error("malformed error word");

   // sigmoid output stays within one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.out_value <= 9'd256) else $error("output out of range");

   // a word is loaded only when the output register is free
   a_load: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.can_load) else $error("result word overwritten");
endmodule
`default_nettype wire

FILE: dv/mlp_sigmoid_forward_pass_test.sv
`timescale 1ns / 1ps
`default_nettype none
module mlp_sigmoid_forward_pass_test;
   import mlpsig_pkg::*;

   localparam logic FUNC_WEIGHT = 1'b0;
   localparam logic FUNC_INPUT  = 1'b1;
   localparam int   CYCLE_LIMIT = 1000000;
   localparam int   DRAIN_WAIT  = 1600;
   localparam int   IDLE_WAIT   = 20;

   typedef struct {
      logic               func;
      logic signed [15:0] value;
      logic               last;
   } req_word_type;

   typedef struct {
      logic [8:0] out_value;
      logic       out_last;
      logic       count_error;
   } rsp_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [CFG_W-1:0] csr_wdata;

   mlpsig_req_if req_bus ();
   mlpsig_rsp_if rsp_bus ();

   mlp_sigmoid_forward_pass u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // stimulus and expectation stores
   req_word_type pending_words[$];
   rsp_word_type neuron_outputs[$];

   // predictor state
   logic [8:0]  sig_lut [256];
   logic [15:0] weight_mem [WEIGHT_DEPTH];
   logic [15:0] layer_act [2][MAX_WIDTH];
   logic [15:0] net_inputs [MAX_WIDTH];
   int          wr_ptr;
   int          in_cnt;
   int          cfg_inputs, cfg_outputs, cfg_hidden, cfg_neurons;

   int fail_count;
   int cycle_count;
   int inference_count;
   int error_count;
   int checked_count;
   int phase_count;
   int weight_hwm;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // build the sigmoid lookup independently
   initial begin
      bit [63:0] e, den, num;
      int d, m;
      for (int i = 0; i < 256; i++) begin
         d = 2 * i + 1 - 256;
         m = (d < 0) ? -d : d;
         e = 64'h1_0000_0000;
         for (int j = 0; j < m; j++) e = (e * 64'd4162825044 + 64'h8000_0000) >> 32;
         den = 64'h1_0000_0000 + e;
         num = (i >= 128) ? 64'h100_0000_0000 : (e << 8);
         sig_lut[i] = 9'((num + den / 2) / den);
      end
   end

   function automatic int clamp_reg(input int v, input int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic int weights_needed(input int ni, input int no, input int nh, input int np);
      return np * (ni + 1) + (nh - 1) * np * (np + 1) + no * (np + 1);
   endfunction

   // evaluate one layer from bank src into the other bank
   task automatic eval_layer(input int src, input int fanin, input int count, inout int addr);
      longint acc, t;
      int w, a, idx;
      for (int n = 0; n < count; n++) begin
         acc = 0;
         for (int k = 0; k < fanin; k++) begin
            w = $signed(weight_mem[addr % WEIGHT_DEPTH]);
            a = $signed(layer_act[src][k]);
            addr++;
            acc = sat32(acc + longint'(w) * longint'(a));
         end
         w = $signed(weight_mem[addr % WEIGHT_DEPTH]);
         addr++;
         acc = sat32(acc - longint'(w) * 256);
         t = acc + 524288;
         idx = (t < 0) ? 0 : int'(t / 4096);
         if (idx > 255) idx = 255;
         layer_act[1 - src][n] = 16'(sig_lut[idx]);
      end
   endtask

   // advance the predictor by one accepted word
   task automatic predict_word(input req_word_type w);
      int got, ni, no, nh, np, addr, src;
      rsp_word_type r;
      if (w.func == FUNC_WEIGHT) begin
         weight_mem[wr_ptr] = w.value;
         wr_ptr = (wr_ptr + 1) % WEIGHT_DEPTH;
         if (w.last) wr_ptr = 0;
      end else begin
         if (in_cnt < MAX_WIDTH) net_inputs[in_cnt] = w.value;
         if (in_cnt < 31) in_cnt++;
         if (w.last) begin
            got = in_cnt;
            in_cnt = 0;
            ni = clamp_reg(cfg_inputs, MAX_WIDTH);
            no = clamp_reg(cfg_outputs, MAX_WIDTH);
            nh = clamp_reg(cfg_hidden, MAX_HIDDEN);
            np = clamp_reg(cfg_neurons, MAX_WIDTH);
            inference_count++;
            if (got != ni) begin
               error_count++;
               r.out_value = '0;
               r.out_last = 1'b1;
               r.count_error = 1'b1;
               neuron_outputs.push_back(r);
            end else begin
               for (int k = 0; k < ni; k++) layer_act[0][k] = net_inputs[k];
               addr = 0;
               src = 0;
               eval_layer(src, ni, np, addr);
               for (int l = 1; l < nh; l++) begin
                  src = 1 - src;
                  eval_layer(src, np, np, addr);
               end
               src = 1 - src;
               eval_layer(src, np, no, addr);
               for (int n = 0; n < no; n++) begin
                  r.out_value = layer_act[1 - src][n][8:0];
                  r.out_last = (n + 1 == no);
                  r.count_error = 1'b0;
                  neuron_outputs.push_back(r);
               end
            end
         end
      end
   endtask

   // request driver
   int req_gap;
   bit req_burst;
   req_word_type req_cur;
   always @(posedge clock) begin
      req_word_type nxt;
      int r;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.func <= FUNC_WEIGHT;
         req_bus.value <= '0;
         req_bus.last <= 1'b0;
         req_gap = 0;
         req_burst = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_word(req_cur);
            if ($urandom_range(99) < 3) req_burst = !req_burst;
            r = $urandom_range(99);
            if (req_burst || r < 60) req_gap = 0;
            else if (r < 95) req_gap = $urandom_range(1, 3);
            else req_gap = $urandom_range(8, 40);
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the word until taken
         end else if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            nxt = pending_words.pop_front();
            req_cur = nxt;
            req_bus.valid <= 1'b1;
            req_bus.func <= nxt.func;
            req_bus.value <= nxt.value;
            req_bus.last <= nxt.last;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response monitor and ready stalls
   int rsp_stall;
   always @(posedge clock) begin
      rsp_word_type e;
      int r;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (neuron_outputs.size() == 0) begin
               $display("%0t: unexpected word value=%0d last=%0b err=%0b", $time,
                        rsp_bus.out_value, rsp_bus.out_last, rsp_bus.count_error);
               fail_count++;
            end else begin
               e = neuron_outputs.pop_front();
               checked_count++;
               if (rsp_bus.out_value !== e.out_value) begin
                  $display("%0t: out_value expected %0d actual %0d", $time,
                           e.out_value, rsp_bus.out_value);
                  fail_count++;
               end
               if (rsp_bus.out_last !== e.out_last) begin
                  $display("%0t: out_last expected %0b actual %0b", $time,
                           e.out_last, rsp_bus.out_last);
                  fail_count++;
               end
               if (rsp_bus.count_error !== e.count_error) begin
                  $display("%0t: count_error expected %0b actual %0b", $time,
                           e.count_error, rsp_bus.count_error);
                  fail_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            r = $urandom_range(99);
            if (r < 70) rsp_stall = 0;
            else if (r < 96) rsp_stall = $urandom_range(1, 3);
            else rsp_stall = $urandom_range(10, 40);
            rsp_bus.ready <= (rsp_stall == 0);
         end
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words outstanding", $time, neuron_outputs.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic signed [15:0] rand_value();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 16'($urandom_range(1023)) - 16'sd512;
      if (r < 85) return 16'($urandom);
      case ($urandom_range(4))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'sh0100;
         default: return 16'shFFFF;
      endcase
   endfunction

   task automatic push_word(input logic func, input logic signed [15:0] v, input logic last);
      req_word_type w;
      w.func = func;
      w.value = v;
      w.last = last;
      pending_words.push_back(w);
   endtask

   task automatic load_weights(input int n);
      for (int i = 0; i < n; i++) push_word(FUNC_WEIGHT, rand_value(), i == n - 1);
      if (n > weight_hwm) weight_hwm = n;
   endtask

   task automatic push_inputs(input int n);
      for (int i = 0; i < n; i++) push_word(FUNC_INPUT, rand_value(), i == n - 1);
   endtask

   // hold until stimulus and expected words have drained
   task automatic wait_drained();
      while (pending_words.size() > 0 || req_bus.valid || neuron_outputs.size() > 0)
         @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input int v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CFG_W'(v);
      case (idx)
         CSR_INPUT_COUNT:  cfg_inputs = v & 31;
         CSR_OUTPUT_COUNT: cfg_outputs = v & 31;
         CSR_HIDDEN:       cfg_hidden = v & 7;
         default:          cfg_neurons = v & 31;
      endcase
   endtask

   task automatic set_network(input int ni, input int no, input int nh, input int np);
      wait_drained();
      write_csr(CSR_INPUT_COUNT, ni);
      write_csr(CSR_OUTPUT_COUNT, no);
      write_csr(CSR_HIDDEN, nh);
      write_csr(CSR_NEURONS, np);
      @(posedge clock);
      csr_we <= 1'b0;
      phase_count++;
   endtask

   // one phase of mostly well-formed inferences
   task automatic run_phase(input int n_inf, input bit allow_reload);
      int ni, need, r;
      ni = clamp_reg(cfg_inputs, MAX_WIDTH);
      need = weights_needed(ni, clamp_reg(cfg_outputs, MAX_WIDTH),
                            clamp_reg(cfg_hidden, MAX_HIDDEN), clamp_reg(cfg_neurons, MAX_WIDTH));
      if (allow_reload || need > weight_hwm) load_weights(need);
      for (int i = 0; i < n_inf; i++) begin
         r = $urandom_range(99);
         if (r < 80) begin
            push_inputs(ni);
         end else if (r < 90) begin
            if ($urandom_range(9) == 0) push_inputs($urandom_range(32, 34));
            else push_inputs($urandom_range(1, 20));
         end else if (r < 95 && allow_reload) begin
            load_weights(need);
         end else if (allow_reload) begin
            load_weights($urandom_range(1, need));
         end else begin
            push_inputs(ni);
         end
      end
   endtask

   initial begin
      fail_count = 0;
      cycle_count = 0;
      inference_count = 0;
      error_count = 0;
      checked_count = 0;
      phase_count = 0;
      weight_hwm = 0;
      wr_ptr = 0;
      in_cnt = 0;
      cfg_inputs = 1;
      cfg_outputs = 1;
      cfg_hidden = 1;
      cfg_neurons = 1;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_INPUT_COUNT;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset configuration, extreme weights and inputs
      push_word(FUNC_WEIGHT, 16'sh7FFF, 1'b0);
      push_word(FUNC_WEIGHT, 16'sh8000, 1'b0);
      push_word(FUNC_WEIGHT, 16'sh0100, 1'b0);
      push_word(FUNC_WEIGHT, 16'shFF00, 1'b1);
      weight_hwm = 4;
      push_word(FUNC_INPUT, 16'sh7FFF, 1'b1);
      push_word(FUNC_INPUT, 16'sh8000, 1'b1);
      push_word(FUNC_INPUT, 16'sh0000, 1'b1);
      // drop a count mismatch and an overflowing input set
      push_inputs(2);
      push_inputs(18);
      wait_drained();

      set_network(0, 0, 0, 0);
      run_phase(12, 1);
      // saturate the input counter once
      push_inputs(34);
      set_network($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 2),
                  $urandom_range(1, 3));
      run_phase(8, 1);
      // registers above range: widest fan-in and output layer, deepest network
      set_network(31, 31, 7, 1);
      run_phase(2, 0);
      // widest hidden layer
      set_network(1, 1, 1, 16);
      run_phase(3, 0);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (neuron_outputs.size() > 0) begin
         $display("%0t: %0d expected words never arrived", $time, neuron_outputs.size());
         fail_count++;
      end
      $display("Ran %0d network settings and %0d inferences, %0d with a bad input count.",
               phase_count, inference_count, error_count);
      $display("Compared %0d output words; %0d mismatches.", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
